[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is active
`define GSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also runs during reset
`define GSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define GSA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/gsa_pkg.sv]
// ----------------------------------------------------------------------------
// gsa_pkg
// shared constants and types of the gmm statistics accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int GAUSS_W   = 6;
    localparam int DIM_W     = 5;
    localparam int MAX_GAUSS = 1 << GAUSS_W;
    localparam int MAX_DIM   = 1 << DIM_W;
    localparam int FO_AW     = GAUSS_W + DIM_W;
    localparam int SO_AW     = GAUSS_W + 2 * DIM_W;
    localparam int FO_DEPTH  = 1 << FO_AW;
    localparam int SO_DEPTH  = 1 << SO_AW;
    localparam int ST_W      = 48;
    localparam int SO_W      = 64;

    localparam logic [2:0] OP_LOAD   = 3'd0;
    localparam logic [2:0] OP_ACC    = 3'd1;
    localparam logic [2:0] OP_MCNT   = 3'd2;
    localparam logic [2:0] OP_MFO    = 3'd3;
    localparam logic [2:0] OP_SCALE  = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;
    localparam logic [2:0] OP_READ   = 3'd6;

    localparam logic [1:0] RSEL_COUNT  = 2'd0;
    localparam logic [1:0] RSEL_FIRST  = 2'd1;
    localparam logic [1:0] RSEL_SECOND = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_SODIS = 2'd2;
    localparam logic [1:0] STAT_SAT   = 2'd3;

    localparam logic [1:0] CFG_GAUSS = 2'd0;
    localparam logic [1:0] CFG_DIM   = 2'd1;
    localparam logic [1:0] CFG_SOEN  = 2'd2;

    typedef enum logic [1:0] {
        SEL_CNT = 2'd0,
        SEL_FO  = 2'd1,
        SEL_SO  = 2'd2
    } sel_t;

    typedef enum logic [9:0] {
        S_INIT = 10'b0000000001,
        S_IDLE = 10'b0000000010,
        S_CLR  = 10'b0000000100,
        S_ROW  = 10'b0000001000,
        S_ROWL = 10'b0000010000,
        S_RD   = 10'b0000100000,
        S_M1   = 10'b0001000000,
        S_M2   = 10'b0010000000,
        S_WR   = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

endpackage

[rtl/gmm_sufficient_stats_accumulator_core.sv]
// ----------------------------------------------------------------------------
// gmm_sufficient_stats_accumulator_core
// per-component count, first and second order statistics in on-chip memories
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata, s_tuser (command)
// m_*      out  m_tvalid/m_tready  m_tdata, m_tuser (result)
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// each entry is read, modified and written back in turn (read, two
// multiply stages, write) before the next entry is read.
// after reset a clearing pass over every store runs before the first command.
// one command at a time; a finished result waits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gmm_sufficient_stats_accumulator_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // gauss_index[5:0] dim_row[10:6] dim_col[15:11] feature_value[31:16]
    // weight[48:32] merge_value[96:49] scale_factor[120:97], zero pad above
    input  logic [127:0] s_tdata,
    // opcode[2:0] read_select[4:3]
    input  logic [4:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_value[63:0]
    output logic [63:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [6:0]   cfg_data
);

    localparam int GW = gsa_pkg::GAUSS_W;
    localparam int DW = gsa_pkg::DIM_W;

    // memories
    logic [gsa_pkg::ST_W-1:0] cnt_mem [gsa_pkg::MAX_GAUSS];
    logic [gsa_pkg::ST_W-1:0] fo_mem  [gsa_pkg::FO_DEPTH];
    logic [gsa_pkg::SO_W-1:0] so_mem  [gsa_pkg::SO_DEPTH];
    logic [15:0]              frame_mem [gsa_pkg::MAX_DIM];
    logic [gsa_pkg::ST_W-1:0] cnt_q, fo_q;
    logic [gsa_pkg::SO_W-1:0] so_q;
    logic signed [15:0]       frame_q;

    gsa_pkg::state_t state_reg, state_next;
    gsa_pkg::sel_t   sel_reg, sel_next;
    logic [gsa_pkg::SO_AW-1:0] idx_reg, idx_next;
    logic [2:0]  op_reg, op_next;
    logic [GW-1:0] g_reg, g_next;
    logic [16:0] w_reg, w_next;
    logic signed [47:0] mv_reg, mv_next;
    logic [23:0] sf_reg, sf_next;
    logic signed [15:0] fj_reg, fj_next;
    logic signed [63:0] cur_reg, cur_next, add_reg, add_next;
    logic signed [31:0] p1_reg, p1_next;
    logic [55:0] plo_reg, plo_next, phi_reg, phi_next;
    logic neg_reg, neg_next, big_reg, big_next, sat_reg, sat_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] pend_val_reg, pend_val_next;
    logic [1:0]  pend_st_reg, pend_st_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_val_reg, out_val_next;
    logic [1:0]  out_st_reg, out_st_next;
    logic [6:0]  gauss_used_reg;
    logic [5:0]  dim_used_reg;
    logic        so_en_reg;

    // input fields
    logic [2:0]  in_op;
    logic [1:0]  in_rsel;
    logic [GW-1:0] in_g;
    logic [DW-1:0] in_r, in_c;
    logic signed [15:0] in_feat;
    logic [16:0] in_w;
    logic signed [47:0] in_mv;
    logic [23:0] in_sf;

    assign in_op   = s_tuser[2:0];
    assign in_rsel = s_tuser[4:3];
    assign in_g    = s_tdata[5:0];
    assign in_r    = s_tdata[10:6];
    assign in_c    = s_tdata[15:11];
    assign in_feat = s_tdata[31:16];
    assign in_w    = s_tdata[48:32];
    assign in_mv   = s_tdata[96:49];
    assign in_sf   = s_tdata[120:97];

    logic [6:0] g_eff;
    logic [5:0] d_eff;
    logic g_ok, r_ok, c_ok, accept;

    assign g_eff = (gauss_used_reg > 7'(gsa_pkg::MAX_GAUSS)) ?
                   7'(gsa_pkg::MAX_GAUSS) : gauss_used_reg;
    assign d_eff = (dim_used_reg > 6'(gsa_pkg::MAX_DIM)) ?
                   6'(gsa_pkg::MAX_DIM) : dim_used_reg;
    assign g_ok  = {1'b0, in_g} < g_eff;
    assign r_ok  = {1'b0, in_r} < d_eff;
    assign c_ok  = {1'b0, in_c} < d_eff;

    assign s_tready = (state_reg == gsa_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_st_reg;

    // memory write control
    logic cnt_we, fo_we, so_we, frame_we;
    logic [63:0] wdata;
    logic [DW-1:0] frame_waddr, frame_raddr;
    logic [15:0] frame_wdata;

    assign frame_raddr = (state_reg == gsa_pkg::S_ROW) ? idx_reg[2*DW-1:DW] : idx_reg[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[idx_reg[GW-1:0]] <= wdata[gsa_pkg::ST_W-1:0];
        end
        cnt_q <= cnt_mem[idx_reg[GW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (fo_we)
        begin
            fo_mem[idx_reg[gsa_pkg::FO_AW-1:0]] <= wdata[gsa_pkg::ST_W-1:0];
        end
        fo_q <= fo_mem[idx_reg[gsa_pkg::FO_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (so_we)
        begin
            so_mem[idx_reg] <= wdata;
        end
        so_q <= so_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        frame_q <= frame_mem[frame_raddr];
    end

    // write-back arithmetic
    logic signed [64:0] sum65, hi65, lo65;
    logic signed [63:0] add_res;
    logic add_sat;
    logic [63:0] lim, qs, sres;
    logic sc_sat, wr_sat;
    logic [63:0] wr_val;

    always_comb
    begin
        sum65 = {cur_reg[63], cur_reg} + {add_reg[63], add_reg};
        if (sel_reg == gsa_pkg::SEL_SO)
        begin
            hi65 = {2'b00, {63{1'b1}}};
            lo65 = {2'b11, 63'd0};
            lim  = 64'h8000_0000_0000_0000 - {63'd0, !neg_reg};
        end
        else
        begin
            hi65 = {18'd0, {47{1'b1}}};
            lo65 = {{18{1'b1}}, 47'd0};
            lim  = 64'h0000_8000_0000_0000 - {63'd0, !neg_reg};
        end
        add_sat = 1'b0;
        if (sum65 > hi65)
        begin
            add_res = hi65[63:0];
            add_sat = 1'b1;
        end
        else if (sum65 < lo65)
        begin
            add_res = lo65[63:0];
            add_sat = 1'b1;
        end
        else
        begin
            add_res = sum65[63:0];
        end
        sc_sat = big_reg || (q_reg > lim);
        qs     = sc_sat ? lim : q_reg;
        sres   = neg_reg ? (64'd0 - qs) : qs;
        if (op_reg == gsa_pkg::OP_SCALE)
        begin
            wr_val = sres;
            wr_sat = sc_sat;
        end
        else
        begin
            wr_val = add_res;
            wr_sat = add_sat;
        end
    end

    logic [DW-1:0] j_f, k_f;
    logic j_more, k_more;
    logic signed [63:0] cur_sel;
    logic [63:0] mag;

    assign j_f    = idx_reg[2*DW-1:DW];
    assign k_f    = idx_reg[DW-1:0];
    assign k_more = (6'({1'b0, k_f}) + 6'd1) < d_eff;
    assign j_more = (6'({1'b0, j_f}) + 6'd1) < d_eff;

    always_comb
    begin
        case (sel_reg)
            gsa_pkg::SEL_CNT: cur_sel = {{16{cnt_q[47]}}, cnt_q};
            gsa_pkg::SEL_FO:  cur_sel = {{16{fo_q[47]}}, fo_q};
            default:          cur_sel = so_q;
        endcase
        mag = cur_sel[63] ? (64'd0 - cur_sel) : cur_sel;
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        g_next         = g_reg;
        w_next         = w_reg;
        mv_next        = mv_reg;
        sf_next        = sf_reg;
        fj_next        = fj_reg;
        cur_next       = cur_reg;
        add_next       = add_reg;
        p1_next        = p1_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        neg_next       = neg_reg;
        big_next       = big_reg;
        q_next         = q_reg;
        sat_next       = sat_reg;
        pend_val_next  = pend_val_reg;
        pend_st_next   = pend_st_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        cnt_we         = 1'b0;
        fo_we          = 1'b0;
        so_we          = 1'b0;
        frame_we       = 1'b0;
        wdata          = wr_val;
        frame_waddr    = in_r;
        frame_wdata    = in_feat;

        unique case (state_reg)
            gsa_pkg::S_INIT, gsa_pkg::S_CLR:
            begin
                cnt_we = 1'b1;
                fo_we  = 1'b1;
                so_we  = 1'b1;
                wdata  = 64'd0;
                if (state_reg == gsa_pkg::S_INIT)
                begin
                    // frame is kept by the clear command, zeroed only here
                    frame_we    = 1'b1;
                    frame_waddr = idx_reg[DW-1:0];
                    frame_wdata = 16'd0;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == gsa_pkg::SO_AW'(gsa_pkg::SO_DEPTH - 1))
                begin
                    state_next = (state_reg == gsa_pkg::S_INIT) ?
                                 gsa_pkg::S_IDLE : gsa_pkg::S_DONE;
                end
            end
            gsa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = in_op;
                    g_next        = in_g;
                    w_next        = in_w;
                    mv_next       = in_mv;
                    sf_next       = in_sf;
                    sat_next      = 1'b0;
                    pend_val_next = 64'd0;
                    pend_st_next  = gsa_pkg::STAT_OK;
                    state_next    = gsa_pkg::S_DONE;
                    case (in_op)
                        gsa_pkg::OP_LOAD:
                        begin
                            if (r_ok) frame_we = 1'b1;
                            else pend_st_next = gsa_pkg::STAT_RANGE;
                        end
                        gsa_pkg::OP_ACC, gsa_pkg::OP_MCNT:
                        begin
                            if (g_ok)
                            begin
                                sel_next   = gsa_pkg::SEL_CNT;
                                idx_next   = gsa_pkg::SO_AW'(in_g);
                                state_next = gsa_pkg::S_RD;
                            end
                            else pend_st_next = gsa_pkg::STAT_RANGE;
                        end
                        gsa_pkg::OP_MFO:
                        begin
                            if (g_ok && r_ok)
                            begin
                                sel_next   = gsa_pkg::SEL_FO;
                                idx_next   = gsa_pkg::SO_AW'({in_g, in_r});
                                state_next = gsa_pkg::S_RD;
                            end
                            else pend_st_next = gsa_pkg::STAT_RANGE;
                        end
                        gsa_pkg::OP_SCALE:
                        begin
                            sel_next   = gsa_pkg::SEL_CNT;
                            idx_next   = '0;
                            state_next = gsa_pkg::S_RD;
                        end
                        gsa_pkg::OP_CLEAR:
                        begin
                            idx_next   = '0;
                            state_next = gsa_pkg::S_CLR;
                        end
                        gsa_pkg::OP_READ:
                        begin
                            case (in_rsel)
                                gsa_pkg::RSEL_COUNT:
                                begin
                                    if (g_ok)
                                    begin
                                        sel_next   = gsa_pkg::SEL_CNT;
                                        idx_next   = gsa_pkg::SO_AW'(in_g);
                                        state_next = gsa_pkg::S_RD;
                                    end
                                    else pend_st_next = gsa_pkg::STAT_RANGE;
                                end
                                gsa_pkg::RSEL_FIRST:
                                begin
                                    if (g_ok && r_ok)
                                    begin
                                        sel_next   = gsa_pkg::SEL_FO;
                                        idx_next   = gsa_pkg::SO_AW'({in_g, in_r});
                                        state_next = gsa_pkg::S_RD;
                                    end
                                    else pend_st_next = gsa_pkg::STAT_RANGE;
                                end
                                gsa_pkg::RSEL_SECOND:
                                begin
                                    if (!so_en_reg) pend_st_next = gsa_pkg::STAT_SODIS;
                                    else if (g_ok && r_ok && c_ok)
                                    begin
                                        sel_next   = gsa_pkg::SEL_SO;
                                        idx_next   = {in_g, in_r, in_c};
                                        state_next = gsa_pkg::S_RD;
                                    end
                                    else pend_st_next = gsa_pkg::STAT_RANGE;
                                end
                                default: pend_st_next = gsa_pkg::STAT_RANGE;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            gsa_pkg::S_ROW:
            begin
                state_next = gsa_pkg::S_ROWL;
            end
            gsa_pkg::S_ROWL:
            begin
                fj_next    = frame_q;
                state_next = gsa_pkg::S_RD;
            end
            gsa_pkg::S_RD:
            begin
                state_next = gsa_pkg::S_M1;
            end
            gsa_pkg::S_M1:
            begin
                cur_next   = cur_sel;
                state_next = gsa_pkg::S_M2;
                neg_next   = cur_sel[63];
                plo_next   = mag[31:0] * sf_reg;
                phi_next   = mag[63:32] * sf_reg;
                p1_next    = fj_reg * frame_q;
                case (op_reg)
                    gsa_pkg::OP_READ:
                    begin
                        pend_val_next = cur_sel;
                        state_next    = gsa_pkg::S_DONE;
                    end
                    gsa_pkg::OP_ACC:
                    begin
                        if (sel_reg == gsa_pkg::SEL_CNT) add_next = {47'd0, w_reg};
                        else add_next = 64'($signed({1'b0, w_reg}) * frame_q);
                    end
                    default: add_next = {{16{mv_reg[47]}}, mv_reg};
                endcase
            end
            gsa_pkg::S_M2:
            begin
                if (op_reg == gsa_pkg::OP_ACC && sel_reg == gsa_pkg::SEL_SO)
                begin
                    add_next = 64'(p1_reg * $signed({1'b0, w_reg}));
                end
                big_next   = |phi_reg[55:47];
                q_next     = (64'(phi_reg) << 16) + 64'(plo_reg[55:16]) + {63'd0, plo_reg[15]};
                state_next = gsa_pkg::S_WR;
            end
            gsa_pkg::S_WR:
            begin
                cnt_we     = (sel_reg == gsa_pkg::SEL_CNT);
                fo_we      = (sel_reg == gsa_pkg::SEL_FO);
                so_we      = (sel_reg == gsa_pkg::SEL_SO);
                sat_next   = sat_reg || wr_sat;
                state_next = gsa_pkg::S_DONE;
                if (op_reg == gsa_pkg::OP_ACC)
                begin
                    case (sel_reg)
                        gsa_pkg::SEL_CNT:
                        begin
                            if (d_eff != 6'd0)
                            begin
                                sel_next   = gsa_pkg::SEL_FO;
                                idx_next   = gsa_pkg::SO_AW'({g_reg, {DW{1'b0}}});
                                state_next = gsa_pkg::S_RD;
                            end
                        end
                        gsa_pkg::SEL_FO:
                        begin
                            if (k_more)
                            begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = gsa_pkg::S_RD;
                            end
                            else if (so_en_reg)
                            begin
                                sel_next   = gsa_pkg::SEL_SO;
                                idx_next   = {g_reg, {(2*DW){1'b0}}};
                                state_next = gsa_pkg::S_ROW;
                            end
                        end
                        default:
                        begin
                            if (k_more)
                            begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = gsa_pkg::S_RD;
                            end
                            else if (j_more)
                            begin
                                idx_next   = {g_reg, j_f + 1'b1, {DW{1'b0}}};
                                state_next = gsa_pkg::S_ROW;
                            end
                        end
                    endcase
                end
                else if (op_reg == gsa_pkg::OP_SCALE)
                begin
                    // sweep count, then first order, then second order
                    state_next = gsa_pkg::S_RD;
                    idx_next   = idx_reg + 1'b1;
                    case (sel_reg)
                        gsa_pkg::SEL_CNT:
                        begin
                            if (idx_reg[GW-1:0] == GW'(gsa_pkg::MAX_GAUSS - 1))
                            begin
                                sel_next = gsa_pkg::SEL_FO;
                                idx_next = '0;
                            end
                        end
                        gsa_pkg::SEL_FO:
                        begin
                            if (idx_reg[gsa_pkg::FO_AW-1:0] ==
                                gsa_pkg::FO_AW'(gsa_pkg::FO_DEPTH - 1))
                            begin
                                sel_next = gsa_pkg::SEL_SO;
                                idx_next = '0;
                            end
                        end
                        default:
                        begin
                            if (idx_reg == gsa_pkg::SO_AW'(gsa_pkg::SO_DEPTH - 1))
                            begin
                                state_next = gsa_pkg::S_DONE;
                            end
                        end
                    endcase
                end
            end
            gsa_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = pend_val_reg;
                    out_st_next    = (sat_reg && pend_st_reg == gsa_pkg::STAT_OK) ?
                                     gsa_pkg::STAT_SAT : pend_st_reg;
                    state_next     = gsa_pkg::S_IDLE;
                end
            end
            default: state_next = gsa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gsa_pkg::S_INIT;
            idx_reg        <= '0;
            sel_reg        <= gsa_pkg::SEL_CNT;
            op_reg         <= gsa_pkg::OP_LOAD;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            gauss_used_reg <= 7'(gsa_pkg::MAX_GAUSS);
            dim_used_reg   <= 6'(gsa_pkg::MAX_DIM);
            so_en_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sel_reg       <= sel_next;
            op_reg        <= op_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    gsa_pkg::CFG_GAUSS: gauss_used_reg <= cfg_data;
                    gsa_pkg::CFG_DIM:   dim_used_reg   <= cfg_data[5:0];
                    gsa_pkg::CFG_SOEN:  so_en_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg        <= g_next;
        w_reg        <= w_next;
        mv_reg       <= mv_next;
        sf_reg       <= sf_next;
        fj_reg       <= fj_next;
        cur_reg      <= cur_next;
        add_reg      <= add_next;
        p1_reg       <= p1_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        neg_reg      <= neg_next;
        big_reg      <= big_next;
        q_reg        <= q_next;
        pend_val_reg <= pend_val_next;
        pend_st_reg  <= pend_st_next;
        out_val_reg  <= out_val_next;
        out_st_reg   <= out_st_next;
    end

    logic load_acc, so_wr, so_wr_ok, wr_phase, done_st;

    assign load_acc = accept && (in_op == gsa_pkg::OP_LOAD);
    assign done_st  = (state_reg == gsa_pkg::S_DONE);
    assign so_wr    = (state_reg == gsa_pkg::S_WR) && (sel_reg == gsa_pkg::SEL_SO);
    assign so_wr_ok = (op_reg == gsa_pkg::OP_SCALE) ||
                      ((op_reg == gsa_pkg::OP_ACC) && so_en_reg);
    assign wr_phase = (state_reg == gsa_pkg::S_WR) || (state_reg == gsa_pkg::S_CLR) ||
                      (state_reg == gsa_pkg::S_INIT);

    `GSA_ASSERT(a_load_done, clk, rst_n, load_acc |=> done_st, "load took more than one cycle")
    `GSA_ASSERT(a_so_write, clk, rst_n, so_wr |-> so_wr_ok, "second order written while disabled")
    `GSA_ASSERT_ALWAYS(a_we_state, clk, cnt_we |-> wr_phase, "count written outside write phase")

endmodule
